// ===== design/aamr_pkg.sv =====
// ----------------------------------------------------------------------------
// aamr_pkg: shared types and helpers of the argmax / argmin reducer
// element formats, register indexes, the position struct and the ordering key
// ----------------------------------------------------------------------------
`default_nettype none

package aamr_pkg;

  // element formats
  typedef enum logic [2:0] {
    DT_INT8  = 3'd0,
    DT_INT16 = 3'd1,
    DT_INT32 = 3'd2,
    DT_INT64 = 3'd3,
    DT_FP16  = 3'd4,
    DT_BF16  = 3'd5,
    DT_FP32  = 3'd6,
    DT_FP64  = 3'd7
  } dtype_e;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_TYPE  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REDUCE_LEN = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEN  = 8'd3;
  localparam int unsigned CFG_DATA_W = 17;

  localparam int unsigned ROW_W = 16;
  localparam int unsigned COL_W = 12;
  localparam int unsigned KEY_W = 64;

  // position of the element being taken, from the sequencer
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             first_row;
    logic             last_row;
    logic             last_col;
  } pos_t;

  function automatic logic [63:0] type_mask(input dtype_e t);
    case (t)
      DT_INT8:                    type_mask = 64'h0000_0000_0000_00FF;
      DT_INT16, DT_FP16, DT_BF16: type_mask = 64'h0000_0000_0000_FFFF;
      DT_INT32, DT_FP32:          type_mask = 64'h0000_0000_FFFF_FFFF;
      default:                    type_mask = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
  endfunction

  function automatic logic [63:0] type_sign(input dtype_e t);
    logic [63:0] m;
    m = type_mask(t);
    type_sign = m & ~(m >> 1);
  endfunction

  function automatic logic [63:0] float_inf(input dtype_e t);
    case (t)
      DT_FP16: float_inf = 64'h0000_0000_0000_7C00;
      DT_BF16: float_inf = 64'h0000_0000_0000_7F80;
      DT_FP32: float_inf = 64'h0000_0000_7F80_0000;
      default: float_inf = 64'h7FF0_0000_0000_0000;
    endcase
  endfunction

  function automatic logic is_float(input dtype_e t);
    logic [2:0] code;
    code = t;
    is_float = code[2];
  endfunction

  function automatic logic is_nan(input logic [63:0] x, input dtype_e t);
    logic [63:0] mag;
    mag = x & type_mask(t) & ~type_sign(t);
    is_nan = is_float(t) && (mag > float_inf(t));
  endfunction

  // monotone unsigned key, -0 folded onto +0
  function automatic logic [63:0] order_key(input logic [63:0] x, input dtype_e t);
    logic [63:0] m;
    logic [63:0] s;
    logic [63:0] xm;
    m  = type_mask(t);
    s  = type_sign(t);
    xm = x & m;
    if (!is_float(t)) begin
      order_key = xm ^ s;
    end else begin
      if ((xm & ~s) == 64'd0) begin
        xm = 64'd0;
      end
      order_key = ((xm & s) != 64'd0) ? (~xm & m) : (xm | s);
    end
  endfunction

  // starting best: lowest value for max, highest for min
  function automatic logic [63:0] extreme_bits(input dtype_e t, input logic m);
    logic [63:0] s;
    s = type_sign(t);
    if (!is_float(t)) begin
      extreme_bits = m ? (s - 64'd1) : s;
    end else begin
      extreme_bits = m ? float_inf(t) : (float_inf(t) | s);
    end
  endfunction

endpackage

`default_nettype wire

// ===== design/aamr_mem.sv =====
// ----------------------------------------------------------------------------
// aamr_mem: per-column best entry store
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module aamr_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12,
  parameter int unsigned DW    = 80
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read before write on a same-address collision
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/aamr_seq.sv =====
// ----------------------------------------------------------------------------
// aamr_seq: row and column sequencer
// tracks the position of the next element and flags the last row and column
// ----------------------------------------------------------------------------
`default_nettype none

module aamr_seq #(
  parameter int unsigned INNER_MAX  = 4096,
  parameter int unsigned REDUCE_MAX = 65536
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  input  wire logic [16:0]   reduce_len_i,
  input  wire logic [12:0]   inner_len_i,
  output aamr_pkg::pos_t     pos_o
);

  import aamr_pkg::*;

  localparam logic [16:0] INNER_LIM  = 17'(INNER_MAX);
  localparam logic [16:0] REDUCE_LIM = 17'(REDUCE_MAX);

  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [16:0]      rlen;
  logic [16:0]      ilen;

  // clamp lengths into range
  always_comb begin
    if (reduce_len_i == 17'd0) begin
      rlen = 17'd1;
    end else if (reduce_len_i > REDUCE_LIM) begin
      rlen = REDUCE_LIM;
    end else begin
      rlen = reduce_len_i;
    end
    if (inner_len_i == 13'd0) begin
      ilen = 17'd1;
    end else if ({4'b0, inner_len_i} > INNER_LIM) begin
      ilen = INNER_LIM;
    end else begin
      ilen = {4'b0, inner_len_i};
    end
  end

  assign pos_o.row       = row_q;
  assign pos_o.col       = col_q;
  assign pos_o.first_row = (row_q == '0);
  assign pos_o.last_row  = ({1'b0, row_q} >= (rlen - 17'd1));
  assign pos_o.last_col  = ({5'b0, col_q} >= (ilen - 17'd1));

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (step_i) begin
      if (pos_o.last_col) begin
        col_d = '0;
        row_d = pos_o.last_row ? '0 : (row_q + ROW_W'(1));
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/axis_argmax_argmin_reducer.sv =====
// ----------------------------------------------------------------------------
// axis_argmax_argmin_reducer: streaming argmax / argmin along one tensor axis
// keeps a best value and row per inner column, emits the winning row per column
// ----------------------------------------------------------------------------
// path: the element transfer loads stage 1 and the ram read register, then the
//   compare and write load the output register, from which the result transfers
// throughput: one element per cycle unless a held result stalls stage 1; one
//   read-modify-write per element on the ram, one-deep forwarding for a repeated column
// reset: counters to zero, registers to their reset values; the column ram is
//   not cleared, every entry is written on row zero before it is read
`default_nettype none

module axis_argmax_argmin_reducer #(
  parameter int unsigned INNER_MAX  = 4096,
  parameter int unsigned REDUCE_MAX = 65536
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // element stream
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  wire logic [63:0]                      s_axis_tdata_i,   // [63:0] element_bits
  // result stream
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  output logic [31:0]                           m_axis_tdata_o,   // [15:0] best_index,
                                                                  // [27:16] column
  output logic                                  m_axis_tlast_o,   // slice_end
  // register writes
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [aamr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [aamr_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  import aamr_pkg::*;

  localparam int unsigned AW = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1;
  localparam int unsigned DW = ROW_W + KEY_W;   // {row, raw value}

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic        mode_q;
  dtype_e      dtype_q;
  logic [16:0] reduce_len_q;
  logic [12:0] inner_len_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= 1'b0;
      dtype_q      <= DT_INT32;
      reduce_len_q <= 17'd1;
      inner_len_q  <= 13'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MODE:       mode_q       <= cfg_data_i[0];
        CFG_DATA_TYPE:  dtype_q      <= dtype_e'(cfg_data_i[2:0]);
        CFG_REDUCE_LEN: reduce_len_q <= cfg_data_i[16:0];
        CFG_INNER_LEN:  inner_len_q  <= cfg_data_i[12:0];
        default: ;      // unknown index, ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // stage 0: position, ordering key, ram read
  // ---------------------------------------------------------------------------
  pos_t             pos;
  logic             accept;
  logic [AW+COL_W-1:0] col_ext;
  logic [AW-1:0]    rd_addr;

  aamr_seq #(
    .INNER_MAX  (INNER_MAX),
    .REDUCE_MAX (REDUCE_MAX)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (accept),
    .reduce_len_i (reduce_len_q),
    .inner_len_i  (inner_len_q),
    .pos_o        (pos)
  );

  // the column never reaches INNER_MAX, so it maps straight onto the ram
  assign col_ext = {{AW{1'b0}}, pos.col};
  assign rd_addr = col_ext[AW-1:0];

  // ---------------------------------------------------------------------------
  // stage 1: compare against stored best and write back
  // ---------------------------------------------------------------------------
  logic              s1_valid_q;
  pos_t              s1_pos_q;
  logic [AW-1:0]     s1_addr_q;
  logic [KEY_W-1:0]  s1_key_q;
  logic [KEY_W-1:0]  s1_val_q;
  logic              s1_nan_q;
  logic              s1_adv;

  logic              fwd_hit_q;
  logic [DW-1:0]     fwd_data_q;

  logic [DW-1:0]     rd_data;
  logic [DW-1:0]     stored;
  logic [KEY_W-1:0]  ext_val;
  logic [KEY_W-1:0]  best_val;
  logic [KEY_W-1:0]  best_key;
  logic              best_nan;
  logic [ROW_W-1:0]  best_row;
  logic              win;
  logic [KEY_W-1:0]  new_val;
  logic [ROW_W-1:0]  new_row;
  logic              wr_en;

  // output slot frees, or this item makes no result
  assign s1_adv = !s1_valid_q || !s1_pos_q.last_row || !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = s1_adv;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign wr_en  = s1_valid_q && s1_adv;

  aamr_mem #(
    .DEPTH (INNER_MAX),
    .AW    (AW),
    .DW    (DW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_addr_q),
    .wdata_i ({new_row, new_val}),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // same column in consecutive cycles: ram still holds the old entry
  assign stored   = fwd_hit_q ? fwd_data_q : rd_data;
  // raw bits are kept so the stored best is judged under the current format
  assign ext_val  = extreme_bits(dtype_q, mode_q);
  assign best_val = s1_pos_q.first_row ? ext_val : stored[KEY_W-1:0];
  assign best_key = order_key(best_val, dtype_q);
  assign best_nan = is_nan(best_val, dtype_q);
  assign best_row = stored[DW-1:KEY_W];
  // strict compare keeps the first row on a tie; nan never wins
  assign win      = !s1_nan_q && !best_nan &&
                    (mode_q ? (s1_key_q < best_key) : (s1_key_q > best_key));
  assign new_val  = win ? s1_val_q : best_val;
  assign new_row  = (win || s1_pos_q.first_row) ? s1_pos_q.row : best_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_q <= accept;
        fwd_hit_q  <= accept && wr_en && (s1_addr_q == rd_addr);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pos_q   <= pos;
      s1_addr_q  <= rd_addr;
      s1_key_q   <= order_key(s_axis_tdata_i, dtype_q);
      s1_val_q   <= s_axis_tdata_i & type_mask(dtype_q);
      s1_nan_q   <= is_nan(s_axis_tdata_i, dtype_q);
      fwd_data_q <= {new_row, new_val};
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  logic             out_valid_q;
  logic [ROW_W-1:0] out_index_q;
  logic [COL_W-1:0] out_col_q;
  logic             out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (wr_en && s1_pos_q.last_row) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && s1_pos_q.last_row) begin
      out_index_q <= new_row;
      out_col_q   <= s1_pos_q.col;
      out_last_q  <= s1_pos_q.last_col;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0, out_col_q, out_index_q};
  assign m_axis_tlast_o  = out_last_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // forwarded entry only exists for an item that is in stage 1
  a_fwd_live : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_hit_q |-> s1_valid_q)
    else $error("forwarded entry without a stage-1 item");

  // a pending result is never overwritten by the next one
  a_no_clobber : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_pos_q.last_row && out_valid_q && !m_axis_tready_i) |-> !wr_en)
    else $error("stage 1 wrote back while the result slot was held");

  // a single-row slice always reports row zero
  a_row0_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && s1_pos_q.first_row && s1_pos_q.last_row) |=> (m_axis_tdata_o[15:0] == 16'd0))
    else $error("row-zero result carries a nonzero index");

  // stage 1 stalls only while it holds a result for a full slot
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (s1_valid_q && s1_pos_q.last_row && out_valid_q))
    else $error("input stalled with no pending result");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the argmax / argmin axis reducer
// streams tensor slices through the element port and compares every winner against
// a directed expectation or a behavioral predictor of per-column best value and position
// ----------------------------------------------------------------------------

module testbench;
  import aamr_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned SETTLE_WAIT  = 6;   // pipeline depth plus margin
  localparam int unsigned MAX_PRINTS   = 30;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 8'hA5;

  // one winner as it leaves the result port
  typedef struct packed {
    logic [15:0] index;
    logic [11:0] column;
    logic        is_last;
  } winner_t;

  // one line of the directed stimulus
  typedef struct {
    bit                   is_reg;
    logic [CFG_IDX_W-1:0] idx;
    logic [63:0]          val;
    bit                   typed;
    winner_t              want;
  } dir_row_t;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic [63:0]           s_tdata = '0;
  logic                  m_tready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  wire                   s_axis_tready_o;
  wire                   m_axis_tvalid_o;
  wire [31:0]            m_axis_tdata_o;
  wire                   m_axis_tlast_o;
  wire                   cfg_ready_o;

  axis_argmax_argmin_reducer u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),         // [63:0] element_bits
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),  // [15:0] best_index, [27:16] column
    .m_axis_tlast_o  (m_axis_tlast_o),  // slice_end
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  // winners still owed by the block, oldest first
  winner_t  pending_winners[$];
  dir_row_t dir_rows[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned elem_count    = 0;
  int unsigned result_count  = 0;
  int unsigned reg_writes    = 0;
  int unsigned mismatches    = 0;
  int unsigned cycles        = 0;

  // predictor copy of the registers and counters
  logic        mode_q  = 1'b0;
  dtype_e      dtype_q = DT_INT32;
  logic [16:0] rlen_q  = 17'd1;
  logic [12:0] ilen_q  = 13'd1;
  logic [15:0] row_cnt = '0;
  logic [11:0] col_cnt = '0;

  // best values are kept as signed ordering keys, -0 and +0 land on the same key
  logic signed [64:0] best_key [0:4095];
  logic [15:0]        best_row [0:4095];

  // --------------------------------------------------------------------------
  // clock, reset and run limit
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d winners outstanding", cycles,
             pending_winners.size());
    $display("TEST FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // element format helpers
  // --------------------------------------------------------------------------
  function automatic int unsigned fmt_width(input dtype_e t);
    case (t)
      DT_INT8:                    return 8;
      DT_INT16, DT_FP16, DT_BF16: return 16;
      DT_INT32, DT_FP32:          return 32;
      default:                    return 64;
    endcase
  endfunction

  function automatic int unsigned frac_bits(input dtype_e t);
    case (t)
      DT_FP16: return 10;
      DT_BF16: return 7;
      DT_FP32: return 23;
      default: return 52;
    endcase
  endfunction

  function automatic logic [63:0] low_mask(input int unsigned n);
    if (n >= 64) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  // magnitude bits of infinity: all-ones exponent, zero fraction
  function automatic logic [63:0] inf_mag(input dtype_e t);
    int unsigned fb;
    int unsigned ew;
    fb = frac_bits(t);
    ew = fmt_width(t) - 1 - fb;
    return ((64'd1 << ew) - 64'd1) << fb;
  endfunction

  // integers by two's complement value, floats by sign and magnitude
  function automatic logic signed [64:0] value_key(input logic [63:0] raw, input dtype_e t);
    logic [63:0] v;
    logic [63:0] mag;
    logic [64:0] u;
    int unsigned w;
    w   = fmt_width(t);
    v   = raw & low_mask(w);
    mag = v & low_mask(w - 1);
    if (t < DT_FP16) begin
      u = {1'b0, v};
      if (v[w-1]) u = u - (65'd1 << w);
      return $signed(u);
    end
    if (v[w-1]) return -$signed({1'b0, mag});
    return $signed({1'b0, mag});
  endfunction

  // key of the value a column starts from: the far end of the type's range
  function automatic logic signed [64:0] start_key(input dtype_e t, input logic m);
    logic signed [64:0] top;
    if (t < DT_FP16) top = $signed({1'b0, low_mask(fmt_width(t) - 1)});
    else             top = $signed({1'b0, inf_mag(t)});
    if (m) return top;
    if (t < DT_FP16) return -top - 65'sd1;
    return -top;
  endfunction

  function automatic logic [16:0] eff_rows();
    if (rlen_q == 17'd0)     return 17'd1;
    if (rlen_q > 17'd65536)  return 17'd65536;
    return rlen_q;
  endfunction

  function automatic logic [12:0] eff_cols();
    if (ilen_q == 13'd0)    return 13'd1;
    if (ilen_q > 13'd4096)  return 13'd4096;
    return ilen_q;
  endfunction

  // --------------------------------------------------------------------------
  // predictor: folds one element into its column, returns 1 when a winner leaves
  // --------------------------------------------------------------------------
  function automatic bit fold_element(input logic [63:0] raw, output winner_t res);
    logic signed [64:0] k;
    logic signed [64:0] sk;
    logic               nan;
    logic               last_row;
    logic               last_col;
    logic [11:0]        col;
    int unsigned        w;
    col = col_cnt;
    w   = fmt_width(dtype_q);
    k   = value_key(raw, dtype_q);
    nan = (dtype_q >= DT_FP16) && ((raw & low_mask(w - 1)) > inf_mag(dtype_q));
    res = '0;

    // strict compare: ties keep the earlier row, a nan never takes over
    if (row_cnt == 16'd0) begin
      sk = start_key(dtype_q, mode_q);
      best_key[col] = (!nan && (mode_q ? (k < sk) : (k > sk))) ? k : sk;
      best_row[col] = '0;
    end else if (!nan && (mode_q ? (k < best_key[col]) : (k > best_key[col]))) begin
      best_key[col] = k;
      best_row[col] = row_cnt;
    end

    last_row = {1'b0, row_cnt} >= eff_rows() - 17'd1;
    last_col = {1'b0, col_cnt} >= eff_cols() - 13'd1;
    res.index   = best_row[col];
    res.column  = col_cnt;
    res.is_last = last_col;

    if (last_col) begin
      col_cnt = '0;
      row_cnt = last_row ? 16'd0 : row_cnt + 16'd1;
    end else begin
      col_cnt = col_cnt + 12'd1;
    end
    return last_row;
  endfunction

  // --------------------------------------------------------------------------
  // element and register drivers
  // --------------------------------------------------------------------------
  task automatic send_elem(input logic [63:0] raw, input bit typed, input winner_t want);
    winner_t w;
    bit      has;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= raw;
    do @(posedge clk_i); while (!s_axis_tready_o);
    elem_count++;
    has = fold_element(raw, w);
    if (typed)    pending_winners.push_back(want);
    else if (has) pending_winners.push_back(w);
  endtask

  // registers change only with the block drained and the pipe settled
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    s_tvalid <= 1'b0;
    while (pending_winners.size() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    reg_writes++;
    case (idx)
      CFG_MODE:       mode_q  = val[0];
      CFG_DATA_TYPE:  dtype_q = dtype_e'(val[2:0]);
      CFG_REDUCE_LEN: rlen_q  = val[16:0];
      CFG_INNER_LEN:  ilen_q  = val[12:0];
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // result side: random stalls, field-by-field compare against the oldest winner
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
  endtask

  initial begin
    winner_t got;
    winner_t exp_w;
    forever begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_tready) begin
        got = {m_axis_tdata_o[15:0], m_axis_tdata_o[27:16], m_axis_tlast_o};
        result_count++;
        if (pending_winners.size() == 0) begin
          report_mismatch("unexpected transfer, column", got.column, -1);
        end else begin
          exp_w = pending_winners.pop_front();
          if (got.index !== exp_w.index)     report_mismatch("best_index", got.index, exp_w.index);
          if (got.column !== exp_w.column)   report_mismatch("column", got.column, exp_w.column);
          if (got.is_last !== exp_w.is_last) report_mismatch("slice_end", got.is_last, exp_w.is_last);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus generation
  // --------------------------------------------------------------------------
  // mix of format corner values, small values that tie, and raw noise;
  // bits above the element width are always random
  function automatic logic [63:0] pick_elem(input dtype_e t);
    logic [63:0] raw;
    logic [63:0] v;
    logic [63:0] sb;
    logic [63:0] inf;
    logic [63:0] m;
    int unsigned w;
    raw = {$urandom, $urandom};
    w   = fmt_width(t);
    m   = low_mask(w);
    sb  = 64'd1 << (w - 1);
    inf = inf_mag(t);
    case ($urandom_range(0, 9))
      0, 1: begin
        if (t < DT_FP16) begin
          case ($urandom_range(0, 4))
            0: v = sb;
            1: v = sb - 64'd1;
            2: v = 64'd0;
            3: v = m;
            default: v = 64'd1;
          endcase
        end else begin
          case ($urandom_range(0, 7))
            0: v = 64'd0;
            1: v = sb;
            2: v = inf;
            3: v = inf | sb;
            4: v = inf + 64'd1;                                   // signaling nan
            5: v = inf | (64'd1 << (frac_bits(t) - 1)) | ($urandom_range(0, 1) ? sb : 64'd0);
            6: v = (inf - 64'd1) | ($urandom_range(0, 1) ? sb : 64'd0);
            default: v = 64'd1 | ($urandom_range(0, 1) ? sb : 64'd0);   // subnormal
          endcase
        end
      end
      2, 3, 4: begin
        v = $urandom_range(0, 3);
        if ($urandom_range(0, 1)) v = (t < DT_FP16) ? ~v : (v | sb);
      end
      default: return raw;
    endcase
    return (raw & ~m) | (v & m);
  endfunction

  // new mode, format and shape; upper data bits carry noise the block must drop
  task automatic pick_config();
    logic [16:0] r;
    logic [16:0] c;
    case ($urandom_range(0, 9))
      0:       r = 17'd0;
      1:       r = 17'd1;
      8:       r = 17'($urandom_range(7, 24));
      9:       r = 17'($urandom_range(25, 64));
      default: r = 17'($urandom_range(2, 6));
    endcase
    if (r > 17'd24) begin
      c = 17'($urandom_range(1, 2));
    end else begin
      case ($urandom_range(0, 9))
        0:       c = 17'd0;
        9:       c = 17'($urandom_range(7, 40));
        default: c = 17'($urandom_range(1, 6));
      endcase
    end
    if ($urandom_range(0, 7) == 0) c[16:13] = 4'($urandom);
    write_reg(CFG_MODE, 17'($urandom));
    write_reg(CFG_DATA_TYPE, 17'($urandom));
    write_reg(CFG_REDUCE_LEN, r);
    write_reg(CFG_INNER_LEN, c);
    if ($urandom_range(0, 9) == 0) write_reg(CFG_UNUSED_IDX, 17'($urandom));
  endtask

  // whole slices only, so the counters are back at zero before any reconfigure
  task automatic run_phase(input int unsigned sp, input int unsigned rp, input int unsigned quota);
    int unsigned sent;
    int unsigned n;
    send_idle_pct = sp;
    recv_idle_pct = rp;
    sent = 0;
    while (sent < quota) begin
      if (sent == 0 || $urandom_range(0, 2) == 0) pick_config();
      n = int'(eff_rows()) * int'(eff_cols());
      repeat (n) send_elem(pick_elem(dtype_q), 1'b0, '0);
      sent += n;
    end
  endtask

  function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    dir_rows.push_back('{1'b1, idx, val, 1'b0, '0});
  endfunction

  function automatic void add_elem(input logic [63:0] val);
    dir_rows.push_back('{1'b0, '0, val, 1'b0, '0});
  endfunction

  function automatic void add_check(input logic [63:0] val, input logic [15:0] index,
                                    input logic [11:0] column, input logic is_last);
    dir_rows.push_back('{1'b0, '0, val, 1'b1, '{index, column, is_last}});
  endfunction

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: int32, max, one row, one column
    add_check(64'h0000_0000_0000_0005, 16'd0, 12'd0, 1'b1);
    add_check(64'h1234_5678_8000_0000, 16'd0, 12'd0, 1'b1);   // equals the start value
    // 3 rows x 2 columns, extreme ties then later winners
    add_reg(CFG_REDUCE_LEN, 64'd3);
    add_reg(CFG_INNER_LEN, 64'd2);
    add_elem(64'h0000_0000_8000_0000);
    add_elem(64'h0000_0000_0000_0007);
    add_elem(64'h0000_0000_8000_0000);
    add_elem(64'h0000_0000_0000_0007);
    add_check(64'h0000_0000_FFFF_FFFF, 16'd2, 12'd0, 1'b0);
    add_check(64'h0000_0000_0000_0009, 16'd2, 12'd1, 1'b1);
    // fp32 min: nan on row zero, infinity tie, signed zeros tie
    add_reg(CFG_MODE, 64'd1);
    add_reg(CFG_DATA_TYPE, 64'(DT_FP32));
    add_elem(64'h0000_0000_7FC0_0000);
    add_elem(64'h0000_0000_8000_0000);
    add_elem(64'h0000_0000_7F80_0000);
    add_elem(64'h0000_0000_0000_0000);
    add_check(64'h0000_0000_3F80_0000, 16'd2, 12'd0, 1'b0);
    add_check(64'h0000_0000_8000_0000, 16'd0, 12'd1, 1'b1);
    // zero lengths fall back to one, unknown index ignored
    add_reg(CFG_MODE, 64'd0);
    add_reg(CFG_DATA_TYPE, 64'(DT_INT8));
    add_reg(CFG_REDUCE_LEN, 64'd0);
    add_reg(CFG_INNER_LEN, 64'd0);
    add_reg(CFG_UNUSED_IDX, 64'h1_FFFF);
    add_check(64'hFFFF_FFFF_FFFF_FF7F, 16'd0, 12'd0, 1'b1);
    // two-row slices per format
    add_reg(CFG_REDUCE_LEN, 64'd2);
    add_reg(CFG_DATA_TYPE, 64'(DT_INT64));
    add_elem(64'h8000_0000_0000_0000);
    add_check(64'h8000_0000_0000_0001, 16'd1, 12'd0, 1'b1);
    add_reg(CFG_DATA_TYPE, 64'(DT_FP16));
    add_elem(64'h0000_0000_0000_FC00);
    add_check(64'h0000_0000_0000_7E00, 16'd0, 12'd0, 1'b1);
    add_reg(CFG_DATA_TYPE, 64'(DT_FP64));
    add_elem(64'h0000_0000_0000_0001);
    add_check(64'h8000_0000_0000_0000, 16'd0, 12'd0, 1'b1);
    add_reg(CFG_MODE, 64'd1);
    add_reg(CFG_DATA_TYPE, 64'(DT_BF16));
    add_elem(64'h0000_0000_0000_7F80);
    add_check(64'h0000_0000_0000_FFC1, 16'd0, 12'd0, 1'b1);
    add_reg(CFG_DATA_TYPE, 64'(DT_INT16));
    add_elem(64'h0000_0000_0000_7FFF);
    add_check(64'h0000_0000_0000_8000, 16'd1, 12'd0, 1'b1);

    send_idle_pct = 22;
    recv_idle_pct = 82;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_reg) write_reg(dir_rows[i].idx, dir_rows[i].val[CFG_DATA_W-1:0]);
      else send_elem(dir_rows[i].val, dir_rows[i].typed, dir_rows[i].want);
    end

    // random slices: busy receiver, then slow sender, then full rate
    run_phase(22, 82, 500);
    run_phase(82, 22, 500);
    run_phase(0, 0, 500);

    s_tvalid <= 1'b0;
    while (pending_winners.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("run: %0d element transfers, %0d result transfers, %0d register writes",
             elem_count, result_count, reg_writes);
    $display("all eight formats in both modes, ties, nan and signed zeros, zero lengths, "
             , "three stall mixes");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
